FILE: hw/rtl/ctcu_pkg.sv
package ctcu_pkg;

    // Control register layout
    localparam int CTRL_W = 12;
    typedef logic [CTRL_W-1:0] t_ctrl;

    localparam int BIT_DOWN = 1;
    localparam int BIT_ARLD = 4;
    localparam int BIT_LOAD = 5;
    localparam int BIT_IEN  = 6;
    localparam int BIT_EN   = 7;
    localparam int BIT_FLAG = 8;
    localparam int BIT_CASC = 11;

    localparam t_ctrl CTRL_WRITABLE = 12'h8F2;

    // Item kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Register word offsets
    localparam logic [2:0] REG_CTRL0  = 3'd0;
    localparam logic [2:0] REG_LOAD0  = 3'd1;
    localparam logic [2:0] REG_COUNT0 = 3'd2;
    localparam logic [2:0] REG_CTRL1  = 3'd4;
    localparam logic [2:0] REG_LOAD1  = 3'd5;
    localparam logic [2:0] REG_COUNT1 = 3'd6;

    // One bus access or tick
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
    } t_req;

    // Result of one item
    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
    } t_rsp;

endpackage

FILE: hw/rtl/ctcu_timer_step.sv
module ctcu_timer_step #(
    parameter int WIDTH = 32
) (
    input  ctcu_pkg::t_ctrl    i_ctrl,
    input  logic [WIDTH-1:0]   i_cnt,
    input  logic [WIDTH-1:0]   i_ld,
    output ctcu_pkg::t_ctrl    o_ctrl,
    output logic [WIDTH-1:0]   o_cnt
);
    import ctcu_pkg::*;

    logic             wrap;
    logic [WIDTH-1:0] stepped;

    // Wrap detect and +/-1, modular in WIDTH bits
    assign wrap    = i_ctrl[BIT_DOWN] ? (i_cnt == '0) : (i_cnt == '1);
    assign stepped = i_ctrl[BIT_DOWN] ? (i_cnt - WIDTH'(1)) : (i_cnt + WIDTH'(1));

    // One tick: load has priority, then counting while enabled
    always_comb begin
        o_ctrl = i_ctrl;
        o_cnt  = i_cnt;
        if (i_ctrl[BIT_LOAD]) begin
            o_cnt = i_ld;
        end else if (i_ctrl[BIT_EN]) begin
            o_cnt = stepped;
            if (wrap) begin
                o_ctrl[BIT_FLAG] = 1'b1;
                if (i_ctrl[BIT_ARLD]) begin
                    o_cnt = i_ld;
                end else begin
                    o_ctrl[BIT_EN] = 1'b0;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/ctcu_regfile.sv
module ctcu_regfile #(
    parameter int WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  ctcu_pkg::t_req i_req,
    output ctcu_pkg::t_rsp o_rsp
);
    import ctcu_pkg::*;

    t_ctrl            r_ctrl0, r_ctrl1, n_ctrl0, n_ctrl1;
    logic [WIDTH-1:0] r_ld0, r_ld1, n_ld0, n_ld1;
    logic [WIDTH-1:0] r_cnt0, r_cnt1, n_cnt0, n_cnt1;

    t_ctrl              s0_ctrl, s1_ctrl, sj_ctrl;
    logic [WIDTH-1:0]   s0_cnt, s1_cnt;
    logic [2*WIDTH-1:0] sj_cnt;
    t_ctrl              wr_ctrl;

    // Independent timers and the joined 2*WIDTH counter
    ctcu_timer_step #(.WIDTH(WIDTH)) u_step0 (
        .i_ctrl(r_ctrl0), .i_cnt(r_cnt0), .i_ld(r_ld0), .o_ctrl(s0_ctrl), .o_cnt(s0_cnt)
    );
    ctcu_timer_step #(.WIDTH(WIDTH)) u_step1 (
        .i_ctrl(r_ctrl1), .i_cnt(r_cnt1), .i_ld(r_ld1), .o_ctrl(s1_ctrl), .o_cnt(s1_cnt)
    );
    ctcu_timer_step #(.WIDTH(2*WIDTH)) u_stepj (
        .i_ctrl(r_ctrl0), .i_cnt({r_cnt1, r_cnt0}), .i_ld({r_ld1, r_ld0}),
        .o_ctrl(sj_ctrl), .o_cnt(sj_cnt)
    );

    // Control write: writable bits, flag is write-one-to-clear
    always_comb begin
        wr_ctrl = i_req.write_data[CTRL_W-1:0] & CTRL_WRITABLE;
        wr_ctrl[BIT_FLAG] = i_req.write_data[BIT_FLAG] ? 1'b0 :
                            ((i_req.reg_index == REG_CTRL0) ? r_ctrl0[BIT_FLAG]
                                                            : r_ctrl1[BIT_FLAG]);
    end

    // Next state
    always_comb begin
        n_ctrl0 = r_ctrl0;
        n_ctrl1 = r_ctrl1;
        n_ld0   = r_ld0;
        n_ld1   = r_ld1;
        n_cnt0  = r_cnt0;
        n_cnt1  = r_cnt1;
        case (i_req.kind)
            KIND_WRITE: begin
                case (i_req.reg_index)
                    REG_CTRL0: begin
                        n_ctrl0 = wr_ctrl;
                        if (wr_ctrl[BIT_LOAD]) begin
                            n_cnt0 = r_ld0;
                            if (wr_ctrl[BIT_CASC]) n_cnt1 = r_ld1;
                        end
                    end
                    REG_LOAD0: n_ld0 = i_req.write_data[WIDTH-1:0];
                    REG_CTRL1: begin
                        n_ctrl1 = wr_ctrl;
                        if (wr_ctrl[BIT_LOAD] && !r_ctrl0[BIT_CASC]) n_cnt1 = r_ld1;
                    end
                    REG_LOAD1: n_ld1 = i_req.write_data[WIDTH-1:0];
                    default: ;
                endcase
            end
            KIND_TICK: begin
                if (r_ctrl0[BIT_CASC]) begin
                    n_ctrl0 = sj_ctrl;
                    n_cnt0  = sj_cnt[WIDTH-1:0];
                    n_cnt1  = sj_cnt[2*WIDTH-1:WIDTH];
                end else begin
                    n_ctrl0 = s0_ctrl;
                    n_cnt0  = s0_cnt;
                    n_ctrl1 = s1_ctrl;
                    n_cnt1  = s1_cnt;
                end
            end
            default: ;
        endcase
    end

    // Read mux and interrupt taken after the update
    always_comb begin
        o_rsp.read_data = '0;
        if (i_req.kind == KIND_READ) begin
            case (i_req.reg_index)
                REG_CTRL0:  o_rsp.read_data = 32'(r_ctrl0);
                REG_LOAD0:  o_rsp.read_data = 32'(r_ld0);
                REG_COUNT0: o_rsp.read_data = 32'(r_cnt0);
                REG_CTRL1:  o_rsp.read_data = 32'(r_ctrl1);
                REG_LOAD1:  o_rsp.read_data = 32'(r_ld1);
                REG_COUNT1: o_rsp.read_data = 32'(r_cnt1);
                default:    o_rsp.read_data = '0;
            endcase
        end
        o_rsp.irq = (n_ctrl0[BIT_FLAG] & n_ctrl0[BIT_IEN]) |
                    (n_ctrl1[BIT_FLAG] & n_ctrl1[BIT_IEN]);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl0 <= '0;
            r_ctrl1 <= '0;
            r_ld0   <= '0;
            r_ld1   <= '0;
            r_cnt0  <= '0;
            r_cnt1  <= '0;
        end else if (i_fire) begin
            r_ctrl0 <= n_ctrl0;
            r_ctrl1 <= n_ctrl1;
            r_ld0   <= n_ld0;
            r_ld1   <= n_ld1;
            r_cnt0  <= n_cnt0;
            r_cnt1  <= n_cnt1;
        end
    end

    // In cascade a tick leaves timer 1's control alone
    a_casc_ctrl1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.kind == KIND_TICK && r_ctrl0[BIT_CASC]) |=> $stable(r_ctrl1))
        else $error("control 1 changed by a cascaded tick");

    // Counter registers are read-only
    a_cnt_ro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.kind == KIND_WRITE &&
         (i_req.reg_index == REG_COUNT0 || i_req.reg_index == REG_COUNT1))
        |=> ($stable(r_cnt0) && $stable(r_cnt1)))
        else $error("counter changed by a counter write");

    // Only reads return data
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.kind != KIND_READ) |-> (o_rsp.read_data == '0))
        else $error("nonzero read data on a non-read item");

endmodule

FILE: hw/rtl/cascaded_timer_counter_unit.sv
// Dual cascadable timer/counter behind a word-indexed register bus.
// Flow: an accepted item waits in the input register until the result register is
// free, then is processed and lands in the result register. Throughput: one item
// per cycle while results are taken; a held result blocks a full input register
// and drops o_in_ready in the same cycle, so at most two items wait inside.
// Reset (i_rst_n low, synchronous) clears all timer registers and both valids.
module cascaded_timer_counter_unit #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic        o_irq
);
    import ctcu_pkg::*;

    logic r_in_valid, n_in_valid;
    t_req r_req;
    logic r_out_valid, n_out_valid;
    t_rsp r_rsp, rsp;
    logic adv;

    // Input register moves forward when the result register is free
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    ctcu_regfile #(.WIDTH(COUNTER_WIDTH)) u_regs (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (adv),
        .i_req  (r_req),
        .o_rsp  (rsp)
    );

    // Valid bookkeeping
    always_comb begin
        n_in_valid  = (i_in_valid && o_in_ready) || (r_in_valid && !adv);
        n_out_valid = adv || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req.kind       <= i_kind;
            r_req.reg_index  <= i_reg_index;
            r_req.write_data <= i_write_data;
        end
        if (adv) begin
            r_rsp <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_rsp.read_data;
    assign o_irq       = r_rsp.irq;

    // A processed item always lands in the result register
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("processed item lost");

    // A stalled item in the input register is held
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_req)))
        else $error("stalled item overwritten");

    // An untaken result is not replaced
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_rsp)))
        else $error("pending result overwritten");

endmodule

FILE: verif/tb_cascaded_timer_counter_unit.sv
module tb_cascaded_timer_counter_unit;
    import ctcu_pkg::*;

    localparam int CW        = 32;
    localparam int N_ITEMS   = 1700;
    localparam int IDLE_STOP = 2000;

    // codes the package leaves unnamed
    localparam logic [1:0] KIND_NONE  = 2'd3;
    localparam logic [2:0] REG_SPARE0 = 3'd3;
    localparam logic [2:0] REG_SPARE1 = 3'd7;

    // control bit masks as bus words
    localparam logic [31:0] M_DOWN = 32'd1 << BIT_DOWN;
    localparam logic [31:0] M_ARLD = 32'd1 << BIT_ARLD;
    localparam logic [31:0] M_LOAD = 32'd1 << BIT_LOAD;
    localparam logic [31:0] M_IEN  = 32'd1 << BIT_IEN;
    localparam logic [31:0] M_EN   = 32'd1 << BIT_EN;
    localparam logic [31:0] M_FLAG = 32'd1 << BIT_FLAG;
    localparam logic [31:0] M_CASC = 32'd1 << BIT_CASC;

    localparam logic [63:0] TOP_HALF = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] TOP_FULL = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
    } t_access;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [1:0]  i_kind       = KIND_READ;
    logic [2:0]  i_reg_index  = REG_CTRL0;
    logic [31:0] i_write_data = 32'h0;
    logic        i_out_ready  = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_read_data;
    logic        o_irq;

    cascaded_timer_counter_unit #(
        .COUNTER_WIDTH(CW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_reg_index (i_reg_index),
        .i_write_data(i_write_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_read_data (o_read_data),
        .o_irq       (o_irq)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow copy of the timer registers
    t_ctrl       ctl0 = '0;
    t_ctrl       ctl1 = '0;
    logic [31:0] ld0  = '0;
    logic [31:0] ld1  = '0;
    logic [31:0] cnt0 = '0;
    logic [31:0] cnt1 = '0;

    t_access access_q[$];
    t_rsp    result_due[$];
    t_rsp    due_rsp;
    int      n_queued   = 0;
    int      n_counted  = 0;
    int      n_accepted = 0;
    int      n_errors   = 0;
    int      idle_cycles = 0;
    logic    steady;
    logic    paused_mid = 1'b0;

    // no random idling on either side in this window
    assign steady = (n_accepted >= 600) && (n_accepted < 900);

    // one tick of a timer; load takes priority, else a wrap sets the flag, then reloads or stops
    function automatic void advance_timer(inout t_ctrl ctl, inout logic [63:0] cnt,
                                          input logic [63:0] ld, input logic [63:0] top);
        logic [63:0] nxt;
        logic        wrap;
        if (ctl[BIT_LOAD]) begin
            cnt = ld;
        end else if (ctl[BIT_EN]) begin
            if (ctl[BIT_DOWN]) begin
                wrap = (cnt == 64'd0);
                nxt  = wrap ? top : cnt - 64'd1;
            end else begin
                wrap = (cnt == top);
                nxt  = wrap ? 64'd0 : cnt + 64'd1;
            end
            if (wrap) begin
                ctl[BIT_FLAG] = 1'b1;
                if (ctl[BIT_ARLD])
                    nxt = ld;
                else
                    ctl[BIT_EN] = 1'b0;
            end
            cnt = nxt & top;
        end
    endfunction

    // flag is write-1-to-clear, other bits take the writable part of the data
    function automatic t_ctrl ctrl_merge(input t_ctrl old, input logic [31:0] wd);
        t_ctrl nxt;
        nxt = wd[CTRL_W-1:0] & CTRL_WRITABLE;
        nxt[BIT_FLAG] = old[BIT_FLAG] & ~wd[BIT_FLAG];
        return nxt;
    endfunction

    // applies one access to the shadow registers and returns its result
    function automatic t_rsp timer_access(input t_access acc);
        t_rsp        r;
        logic [63:0] c;
        r.read_data = 32'h0;
        case (acc.kind)
            KIND_READ: begin
                case (acc.reg_index)
                    REG_CTRL0:  r.read_data = {{(32-CTRL_W){1'b0}}, ctl0};
                    REG_LOAD0:  r.read_data = ld0;
                    REG_COUNT0: r.read_data = cnt0;
                    REG_CTRL1:  r.read_data = {{(32-CTRL_W){1'b0}}, ctl1};
                    REG_LOAD1:  r.read_data = ld1;
                    REG_COUNT1: r.read_data = cnt1;
                    default:    r.read_data = 32'h0;
                endcase
            end
            KIND_WRITE: begin
                case (acc.reg_index)
                    REG_CTRL0: begin
                        ctl0 = ctrl_merge(ctl0, acc.write_data);
                        if (ctl0[BIT_LOAD]) begin
                            cnt0 = ld0;
                            if (ctl0[BIT_CASC])
                                cnt1 = ld1;
                        end
                    end
                    REG_LOAD0: ld0 = acc.write_data;
                    REG_CTRL1: begin
                        ctl1 = ctrl_merge(ctl1, acc.write_data);
                        if (ctl1[BIT_LOAD] && !ctl0[BIT_CASC])
                            cnt1 = ld1;
                    end
                    REG_LOAD1: ld1 = acc.write_data;
                    default: ;
                endcase
            end
            KIND_TICK: begin
                if (ctl0[BIT_CASC]) begin
                    c = {cnt1, cnt0};
                    advance_timer(ctl0, c, {ld1, ld0}, TOP_FULL);
                    cnt0 = c[31:0];
                    cnt1 = c[63:32];
                end else begin
                    c = {32'h0, cnt0};
                    advance_timer(ctl0, c, {32'h0, ld0}, TOP_HALF);
                    cnt0 = c[31:0];
                    c = {32'h0, cnt1};
                    advance_timer(ctl1, c, {32'h0, ld1}, TOP_HALF);
                    cnt1 = c[31:0];
                end
            end
            default: ;
        endcase
        r.irq = (ctl0[BIT_FLAG] & ctl0[BIT_IEN]) | (ctl1[BIT_FLAG] & ctl1[BIT_IEN]);
        return r;
    endfunction

    task automatic add_access(input logic [1:0] kind, input logic [2:0] idx,
                              input logic [31:0] wd);
        t_access acc;
        acc.kind       = kind;
        acc.reg_index  = idx;
        acc.write_data = wd;
        access_q.push_back(acc);
        n_queued++;
        // writes the block drops and the unused kind do not count
        if (!(kind == KIND_NONE || (kind == KIND_WRITE &&
              (idx == REG_COUNT0 || idx == REG_COUNT1 ||
               idx == REG_SPARE0 || idx == REG_SPARE1))))
            n_counted++;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || result_due.size() != 0)
            @(posedge i_clk);
    endtask

    // a value within three steps of zero or of all ones
    function automatic logic [31:0] near_limit(input logic high);
        logic [31:0] off;
        off = $urandom_range(0, 3);
        return high ? 32'hFFFF_FFFF - off : off;
    endfunction

    // load a timer close to its wrap point, start it, tick it, which may carry it past the wrap
    task automatic add_arm_sequence();
        logic        timer1;
        logic        down;
        logic        casc;
        logic [2:0]  ctl_reg;
        logic [31:0] wd;
        int          n_ticks;
        timer1  = 1'($urandom_range(0, 1));
        down    = 1'($urandom_range(0, 1));
        casc    = !timer1 && ($urandom_range(0, 2) == 0);
        ctl_reg = timer1 ? REG_CTRL1 : REG_CTRL0;
        if (timer1 && $urandom_range(0, 1)) begin
            wd = $urandom;
            wd[BIT_CASC] = 1'b0;
            wd[BIT_LOAD] = 1'b0;
            add_access(KIND_WRITE, REG_CTRL0, wd);
        end
        add_access(KIND_WRITE, timer1 ? REG_LOAD1 : REG_LOAD0, near_limit(!down));
        if (casc)
            add_access(KIND_WRITE, REG_LOAD1,
                       $urandom_range(0, 1) ? near_limit(!down) : $urandom);
        wd = $urandom;
        wd[BIT_LOAD] = 1'b1;
        wd[BIT_CASC] = casc;
        add_access(KIND_WRITE, ctl_reg, wd);
        wd = $urandom;
        wd[BIT_LOAD] = 1'b0;
        wd[BIT_EN]   = 1'b1;
        wd[BIT_DOWN] = down;
        wd[BIT_CASC] = casc;
        add_access(KIND_WRITE, ctl_reg, wd);
        n_ticks = $urandom_range(1, 8);
        repeat (n_ticks) begin
            add_access(KIND_TICK, 3'($urandom_range(0, 7)), $urandom);
            if ($urandom_range(0, 3) == 0)
                add_access(KIND_READ, 3'($urandom_range(0, 7)), $urandom);
        end
        add_access(KIND_READ, ctl_reg, $urandom);
        add_access(KIND_READ, timer1 ? REG_COUNT1 : REG_COUNT0, $urandom);
    endtask

    task automatic add_noise();
        int          pick;
        logic [1:0]  kind;
        logic [2:0]  idx;
        logic [31:0] wd;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            kind = KIND_TICK;
        else if (pick < 65)
            kind = KIND_READ;
        else if (pick < 95)
            kind = KIND_WRITE;
        else
            kind = KIND_NONE;
        idx = 3'($urandom_range(0, 7));
        wd  = $urandom;
        if ((idx == REG_LOAD0 || idx == REG_LOAD1) && $urandom_range(0, 1))
            wd = near_limit(1'($urandom_range(0, 1)));
        if ((idx == REG_CTRL0 || idx == REG_CTRL1) && $urandom_range(0, 3) != 0)
            wd[BIT_LOAD] = 1'b0;
        add_access(kind, idx, wd);
    endtask

    // driver: predicts on acceptance, then offers the next pending access
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                result_due.push_back(timer_access({i_kind, i_reg_index, i_write_data}));
                n_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (access_q.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
                    i_kind       <= access_q[0].kind;
                    i_reg_index  <= access_q[0].reg_index;
                    i_write_data <= access_q[0].write_data;
                    access_q.pop_front();
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: each result against the oldest outstanding one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (result_due.size() == 0) begin
                    $error("result item with nothing outstanding");
                    n_errors++;
                end else begin
                    due_rsp = result_due.pop_front();
                    if (o_read_data !== due_rsp.read_data) begin
                        $error("read_data: expected %h, got %h", due_rsp.read_data, o_read_data);
                        n_errors++;
                    end
                    if (o_irq !== due_rsp.irq) begin
                        $error("irq: expected %b, got %b", due_rsp.irq, o_irq);
                        n_errors++;
                    end
                end
            end
            i_out_ready <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_STOP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: spare read, one-shot up wrap, auto-reload down wrap
        add_access(KIND_READ,  REG_SPARE1, 32'h0);
        add_access(KIND_WRITE, REG_LOAD0,  32'hFFFF_FFFE);
        add_access(KIND_WRITE, REG_CTRL0,  M_LOAD);
        add_access(KIND_READ,  REG_COUNT0, 32'h0);
        add_access(KIND_WRITE, REG_CTRL0,  M_EN | M_IEN);
        add_access(KIND_TICK,  REG_CTRL0,  32'h0);
        add_access(KIND_TICK,  REG_CTRL0,  32'h0);
        add_access(KIND_TICK,  REG_CTRL0,  32'h0);
        add_access(KIND_READ,  REG_CTRL0,  32'h0);
        add_access(KIND_WRITE, REG_CTRL0,  M_FLAG | M_DOWN | M_EN | M_ARLD);
        add_access(KIND_TICK,  REG_CTRL0,  32'h0);
        add_access(KIND_READ,  REG_COUNT0, 32'h0);
        // dropped writes and the unused kind
        add_access(KIND_WRITE, REG_COUNT0, 32'hFFFF_FFFF);
        add_access(KIND_WRITE, REG_SPARE0, 32'hFFFF_FFFF);
        add_access(KIND_NONE,  REG_SPARE1, 32'hFFFF_FFFF);
        // 64-bit cascade wrap; control 1 load is held off while cascaded
        add_access(KIND_WRITE, REG_LOAD1,  32'hFFFF_FFFF);
        add_access(KIND_WRITE, REG_LOAD0,  32'hFFFF_FFFF);
        add_access(KIND_WRITE, REG_CTRL0,  M_CASC | M_LOAD);
        add_access(KIND_WRITE, REG_CTRL1,  M_LOAD | M_EN);
        add_access(KIND_WRITE, REG_CTRL0,  M_CASC | M_EN | M_IEN);
        add_access(KIND_TICK,  REG_CTRL0,  32'h0);
        add_access(KIND_READ,  REG_COUNT1, 32'h0);
        add_access(KIND_WRITE, REG_CTRL1,  32'hFFFF_FFFF);
        add_access(KIND_WRITE, REG_CTRL0,  M_FLAG);
        add_access(KIND_TICK,  REG_CTRL0,  32'h0);
        add_access(KIND_READ,  REG_CTRL1,  32'h0);
        wait_drained();

        // random: mostly armed timers, some loose traffic
        n_counted = 0;
        while (n_counted < N_ITEMS) begin
            if ($urandom_range(0, 9) < 7)
                add_arm_sequence();
            else
                repeat ($urandom_range(1, 6)) add_noise();
            if (!paused_mid && n_counted >= N_ITEMS / 2) begin
                paused_mid = 1'b1;
                wait_drained();
            end
        end
        wait_drained();
        repeat (4) @(posedge i_clk);

        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
